>>> rtl/smnp_pkg.sv
// shared types, character codes and helpers for the sensor message number parser
`timescale 1ns / 1ps
package smnp_pkg;

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // widest digit weight is 9 * 10^6
  localparam int PROD_W = 24;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_KIND = 3'd1,
    PH_SKIP = 3'd2,
    PH_NUM  = 3'd3,
    PH_STOP = 3'd4,
    PH_DISC = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NODIG = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic       is_negative;
    logic       point_seen;
    logic       digit_seen;
    logic [2:0] fraction_count;
    logic       overflowed;
  } num_t;

  typedef struct packed {
    logic        sensor_kind;
    logic [31:0] reading;
    status_t     status;
  } res_t;

  function automatic logic [19:0] pow10(input logic [2:0] idx);
    logic [19:0] p;
    case (idx)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_MINUS;
  endfunction

endpackage

>>> rtl/smnp_finish.sv
// turns the parsed magnitude and flags into a signed, saturated reading
`timescale 1ns / 1ps
module smnp_finish import smnp_pkg::*; #(
  parameter int MAG_W = 32
) (
  input  logic             kind,
  input  num_t             num,
  input  logic [MAG_W-1:0] magnitude,
  output res_t             res
);

  localparam logic [31:0] LIMIT = 32'(64'(1) << (MAG_W - 1));

  logic [31:0] mag32;

  assign mag32 = 32'(magnitude);

  always_comb begin
    res.sensor_kind = kind;
    res.reading     = '0;
    res.status      = ST_OK;
    if (!num.digit_seen) begin
      res.status = ST_NODIG;
    end else if (num.is_negative) begin
      // magnitude is capped at the limit, so negating it never goes below the lower bound
      if (num.overflowed) res.status = ST_SAT;
      res.reading = 32'd0 - mag32;
    end else if (num.overflowed || mag32 >= LIMIT) begin
      res.status  = ST_SAT;
      res.reading = LIMIT - 32'd1;
    end else begin
      res.reading = mag32;
    end
  end

endmodule

>>> rtl/smnp_core.sv
// message phase and number state registers with the per-byte update logic
`timescale 1ns / 1ps
module smnp_core import smnp_pkg::*; #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  input  logic       end_of_burst,
  output logic       res_valid,
  output res_t       res
);

  localparam int EFF_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int MAG_W    = EFF_BITS;
  localparam int SUM_W    = ((EFF_BITS + 3) > PROD_W ? (EFF_BITS + 3) : PROD_W) + 1;
  localparam logic [SUM_W-1:0] LIMIT    = SUM_W'(1) << (EFF_BITS - 1);
  localparam logic [2:0]       FRAC_MAX = 3'(FRAC_DIGITS);
  localparam logic [19:0]      POW_INT  = pow10(FRAC_MAX);

  phase_t           phase, phase_next;
  logic             reading_kind, kind_next;
  num_t             num, num_next, tk_num, fin_num;
  logic [MAG_W-1:0] magnitude, mag_next, tk_mag, fin_mag;
  logic             tk_stop;
  logic             emit;

  logic [3:0]       digit;
  logic [2:0]       fc_inc;
  logic [SUM_W-1:0] m_ext, int_sum, frac_sum, sum;
  logic             upd;

  assign digit    = rx_byte[3:0];
  assign fc_inc   = num.fraction_count + 3'd1;
  assign m_ext    = SUM_W'(magnitude);
  assign int_sum  = (m_ext << 3) + (m_ext << 1) + SUM_W'(digit) * SUM_W'(POW_INT);
  assign frac_sum = m_ext + SUM_W'(digit) * SUM_W'(pow10(FRAC_MAX - fc_inc));

  // one number character applied to the number state
  always_comb begin
    tk_num  = num;
    tk_mag  = magnitude;
    tk_stop = 1'b0;
    sum     = int_sum;
    upd     = 1'b0;
    if (rx_byte == CH_MINUS) begin
      if (!num.digit_seen && !num.point_seen && !num.is_negative) tk_num.is_negative = 1'b1;
      else tk_stop = 1'b1;
    end else if (rx_byte == CH_DOT) begin
      if (num.point_seen) tk_stop = 1'b1;
      else tk_num.point_seen = 1'b1;
    end else begin
      tk_num.digit_seen = 1'b1;
      if (!num.point_seen) begin
        sum = int_sum;
        upd = 1'b1;
      end else if (num.fraction_count < FRAC_MAX) begin
        // surplus fraction digits fall through untouched
        tk_num.fraction_count = fc_inc;
        sum = frac_sum;
        upd = 1'b1;
      end
      if (upd) begin
        if (sum > LIMIT) begin
          tk_mag            = MAG_W'(LIMIT);
          tk_num.overflowed = 1'b1;
        end else begin
          tk_mag = MAG_W'(sum);
        end
      end
    end
  end

  always_comb begin
    phase_next = phase;
    kind_next  = reading_kind;
    num_next   = num;
    mag_next   = magnitude;
    emit       = 1'b0;
    fin_num    = num;
    fin_mag    = magnitude;
    unique case (phase)
      PH_KIND: begin
        if (rx_byte == CH_R) begin
          kind_next  = 1'b0;
          phase_next = PH_SKIP;
        end else if (rx_byte == CH_U) begin
          kind_next  = 1'b1;
          num_next   = '0;
          mag_next   = '0;
          phase_next = PH_NUM;
          if (end_of_burst) begin
            emit    = 1'b1;
            fin_num = '0;
            fin_mag = '0;
          end
        end else begin
          phase_next = end_of_burst ? PH_WAIT : PH_DISC;
        end
      end
      PH_SKIP: begin
        num_next   = '0;
        mag_next   = '0;
        phase_next = PH_NUM;
        if (end_of_burst) begin
          emit    = 1'b1;
          fin_num = '0;
          fin_mag = '0;
        end
      end
      PH_NUM, PH_STOP: begin
        if (!is_num_char(rx_byte)) begin
          emit = 1'b1;
        end else begin
          if (phase == PH_NUM) begin
            num_next   = tk_num;
            mag_next   = tk_mag;
            phase_next = tk_stop ? PH_STOP : PH_NUM;
          end
          if (end_of_burst) begin
            emit    = 1'b1;
            fin_num = num_next;
            fin_mag = mag_next;
          end
        end
      end
      PH_DISC: begin
        if (!is_num_char(rx_byte) || end_of_burst) phase_next = PH_WAIT;
      end
      default: begin
        phase_next = (rx_byte == CH_L) ? PH_KIND : PH_WAIT;
      end
    endcase
    if (emit) begin
      phase_next = PH_WAIT;
      num_next   = '0;
      mag_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      reading_kind <= 1'b0;
      num          <= '0;
      magnitude    <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      reading_kind <= kind_next;
      num          <= num_next;
      magnitude    <= mag_next;
    end
  end

  smnp_finish #(
    .MAG_W(MAG_W)
  ) u_finish (
    .kind     (kind_next),
    .num      (fin_num),
    .magnitude(fin_mag),
    .res      (res)
  );

  assign res_valid = step_en && emit;

endmodule

>>> rtl/sensor_message_number_parser_unit.sv
// top level: input register, byte parser core and output register
`timescale 1ns / 1ps
// the byte that ends a number passes the input register, the core and then the output register
// throughput: one byte per cycle unless a stalled output holds it, set by the core's state update
// the input register is held only while the output register is full and stalled
// reset: synchronous, active high; waits for the header letter with all number state clear
module sensor_message_number_parser_unit import smnp_pkg::*; #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_burst,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sensor_kind,
  output logic [31:0] reading,
  output logic [1:0]  parse_status
);

  localparam int          EFF_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam logic [31:0] SAT_POS  = 32'((64'(1) << (EFF_BITS - 1)) - 64'd1);
  localparam logic [31:0] SAT_NEG  = 32'd0 - 32'(64'(1) << (EFF_BITS - 1));

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= rx_byte;
      in_q_last <= end_of_burst;
    end
  end

  smnp_core #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .rx_byte     (in_q_byte),
    .end_of_burst(in_q_last),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign sensor_kind  = out_res.sensor_kind;
  assign reading      = out_res.reading;
  assign parse_status = out_res.status;

  // a number with no digits always reads as zero
  a_nodig_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == ST_NODIG |-> reading == 32'd0)
    else $error("no-digit transaction with non-zero reading");

  // saturation lands exactly on one of the two bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == ST_SAT |-> reading == SAT_POS || reading == SAT_NEG)
    else $error("saturated transaction off the bounds");

  // a held input byte is not lost or overwritten while the output is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && in_stall |=> in_q_valid && $stable(in_q_byte) && $stable(in_q_last))
    else $error("input register changed while stalled");

  // the core only steps when the output register can take a transaction
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> advance && out_free)
    else $error("result produced without room in the output register");

endmodule
